@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one samples on clk_i and is
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/vfpf_pkg.sv @@
// ----------------------------------------------------------------------------
// vfpf_pkg
// Types and constants shared by the voxel first point filter modules.
// ----------------------------------------------------------------------------
package vfpf_pkg;

  // Region geometry. The bitmap is kept as SIDE*SIDE rows of SIDE bits.
  localparam int SIDE   = 32;
  localparam int IDX_W  = $clog2(SIDE);
  localparam int ROWS   = SIDE * SIDE;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELLS  = SIDE * SIDE * SIDE;
  localparam int CELL_W = $clog2(CELLS);

  // Fixed field widths.
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int FRAC_W  = 32;
  localparam int VIDX_W  = 15;
  localparam int CNT_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [COORD_W-1:0] RECIP_RESET = 24'h010000;

  // Queue between front and back, and the result queue.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int RDEPTH = 4;
  localparam int RPTR_W = $clog2(RDEPTH);
  localparam int RCNT_W = $clog2(RDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_CENTRE_X = 3'd3,
    REG_CENTRE_Y = 3'd4,
    REG_CENTRE_Z = 3'd5,
    REG_RECIP    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
    logic        [COORD_W-1:0] voxel_reciprocal;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                      kept;
    logic        [VIDX_W-1:0]  voxel_index;
    logic        [VIDX_W-1:0]  point_id;
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
    logic        [CNT_W-1:0]   kept_count;
  } result_t;

  // A classified point on its way from the front to the back.
  typedef struct packed {
    logic                      in_region;
    logic        [ROW_W-1:0]   row;
    logic        [IDX_W-1:0]   col;
    logic        [VIDX_W-1:0]  vidx;
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
  } task_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

@@ sv/vfpf_front.sv @@
// ----------------------------------------------------------------------------
// vfpf_front
// Accepts points, computes the per-axis voxel index in two stages and
// classifies each point before it enters the task queue.
// ----------------------------------------------------------------------------
module vfpf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfpf_pkg::cfg_t      cfg_i,
  input  logic                clr_busy_i,
  input  logic                push,
  input  vfpf_pkg::point_t    point_i,
  output logic                full,
  input  vfpf_pkg::q_status_t q_status_i,
  output logic                task_push_o,
  output vfpf_pkg::task_t     task_o
);
  import vfpf_pkg::*;

  // Saturating 24 bit difference.
  function automatic logic signed [COORD_W-1:0] sat_sub(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    if (d[DIFF_W-1] != d[DIFF_W-2]) begin
      sat_sub = d[DIFF_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_sub = d[COORD_W-1:0];
    end
  endfunction

  // A product lies in the region when it is not negative and its integer
  // part is below SIDE.
  function automatic logic axis_in(input logic signed [PROD_W-1:0] p);
    axis_in = !p[PROD_W-1] && (p[PROD_W-1:FRAC_W] < (PROD_W-FRAC_W)'(SIDE));
  endfunction

  logic                      accept;
  logic                      s1_v_q, s2_v_q;
  logic signed [DIFF_W-1:0]  s1_dx_q, s1_dy_q, s1_dz_q;
  point_t                    s1_pt_q;
  logic signed [PROD_W-1:0]  s2_px_q, s2_py_q, s2_pz_q;
  logic signed [COORD_W-1:0] s2_rx_q, s2_ry_q, s2_rz_q;
  logic signed [DIFF_W-1:0]  recip_s;
  logic [QCNT_W:0]           credit;
  logic [IDX_W-1:0]          ix, iy, iz;
  logic [ROW_W-1:0]          row;
  logic [CELL_W-1:0]         map_addr;

  // Items in flight in the front count against the queue space.
  assign credit = (QCNT_W+1)'(q_status_i.count) + (QCNT_W+1)'(s1_v_q)
                + (QCNT_W+1)'(s2_v_q);
  assign full   = clr_busy_i || (credit >= (QCNT_W+1)'(QDEPTH));
  assign accept = push && !full;

  assign recip_s = $signed({1'b0, cfg_i.voxel_reciprocal});

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  // Stage one: offset from the grid corner. Stage two: scale by the
  // reciprocal and form the centroid-relative coordinates.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pt_q <= point_i;
      s1_dx_q <= DIFF_W'(point_i.point_x) - DIFF_W'(cfg_i.origin_x);
      s1_dy_q <= DIFF_W'(point_i.point_y) - DIFF_W'(cfg_i.origin_y);
      s1_dz_q <= DIFF_W'(point_i.point_z) - DIFF_W'(cfg_i.origin_z);
    end
    if (s1_v_q) begin
      s2_px_q <= s1_dx_q * recip_s;
      s2_py_q <= s1_dy_q * recip_s;
      s2_pz_q <= s1_dz_q * recip_s;
      s2_rx_q <= sat_sub(s1_pt_q.point_x, cfg_i.centre_x);
      s2_ry_q <= sat_sub(s1_pt_q.point_y, cfg_i.centre_y);
      s2_rz_q <= sat_sub(s1_pt_q.point_z, cfg_i.centre_z);
    end
  end

  // Classification: region check and row/column of the bitmap.
  assign ix       = s2_px_q[FRAC_W +: IDX_W];
  assign iy       = s2_py_q[FRAC_W +: IDX_W];
  assign iz       = s2_pz_q[FRAC_W +: IDX_W];
  assign row      = ROW_W'(ROW_W'(iz) * ROW_W'(SIDE) + ROW_W'(iy));
  assign map_addr = CELL_W'(CELL_W'(row) * CELL_W'(SIDE) + CELL_W'(ix));

  always_comb begin
    task_o.in_region = axis_in(s2_px_q) && axis_in(s2_py_q) && axis_in(s2_pz_q);
    task_o.row       = row;
    task_o.col       = ix;
    task_o.vidx      = VIDX_W'(map_addr);
    task_o.rel_x     = s2_rx_q;
    task_o.rel_y     = s2_ry_q;
    task_o.rel_z     = s2_rz_q;
  end

  assign task_push_o = s2_v_q;

endmodule

@@ sv/vfpf_task_queue.sv @@
// ----------------------------------------------------------------------------
// vfpf_task_queue
// Short queue of classified points between the front and the back.
// ----------------------------------------------------------------------------
module vfpf_task_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vfpf_pkg::task_t     task_i,
  input  logic                pop_i,
  output vfpf_pkg::task_t     task_o,
  output vfpf_pkg::q_status_t status_o
);
  import vfpf_pkg::*;

  `include "assert_macros.svh"

  task_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= QCNT_W'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= QCNT_W'(count_q - 1'b1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= task_i;
    end
  end

  assign task_o         = entry_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

  // The front's credit check must keep the queue from overflowing.
  `ASSERT_IMPLIES(a_no_overflow, push_i && !pop_i, count_q != QCNT_W'(QDEPTH), "task queue overflow")
  `ASSERT_IMPLIES(a_no_underflow, pop_i, count_q != '0, "task queue popped while empty")

endmodule

@@ sv/vfpf_back.sv @@
// ----------------------------------------------------------------------------
// vfpf_back
// Clears the visited bitmap after reset, then does the bitmap
// read-modify-write, assigns ids and queues the results.
// ----------------------------------------------------------------------------
module vfpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfpf_pkg::q_status_t q_status_i,
  input  vfpf_pkg::task_t     task_i,
  output logic                task_pop_o,
  output logic                clr_busy_o,
  input  logic                pop,
  output vfpf_pkg::result_t   result_o,
  output logic                empty
);
  import vfpf_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  clr_row_q, clr_row_d;
  logic              clearing;
  logic              take;
  logic              b_v_q;
  task_t             b_task_q;
  logic [SIDE-1:0]   map_mem [ROWS];
  logic [SIDE-1:0]   rd_row_q;
  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [SIDE-1:0]   mem_wdata;
  logic              fwd_v_q;
  logic [ROW_W-1:0]  fwd_row_q;
  logic [SIDE-1:0]   fwd_data_q;
  logic [SIDE-1:0]   row_data, new_row;
  logic              kept;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  result_t           res;
  result_t           res_mem [RDEPTH];
  logic [RPTR_W-1:0] res_wr_q, res_rd_q;
  logic [RCNT_W-1:0] res_cnt_q;
  logic              res_pop;

  // Clearing pass over all bitmap rows, then normal operation.
  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_row_d = ROW_W'(clr_row_q + 1'b1);
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign clearing   = (state_q == ST_CLEAR);
  assign clr_busy_o = clearing;

  // Take a task only when the result queue has room for it.
  assign take = !clearing && !q_status_i.empty &&
                ((RCNT_W+1)'(res_cnt_q) + (RCNT_W+1)'(b_v_q) < (RCNT_W+1)'(RDEPTH));
  assign task_pop_o = take;

  // The registered row read misses only the write made in the cycle of that read.
  assign row_data = (fwd_v_q && (fwd_row_q == b_task_q.row)) ? fwd_data_q : rd_row_q;
  assign kept     = b_v_q && b_task_q.in_region && !row_data[b_task_q.col];

  always_comb begin
    new_row                = row_data;
    new_row[b_task_q.col]  = 1'b1;
  end

  assign mem_we    = clearing || kept;
  assign mem_waddr = clearing ? clr_row_q : b_task_q.row;
  assign mem_wdata = clearing ? '0 : new_row;

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (take) begin
      rd_row_q <= map_mem[task_i.row];
    end
  end

  // Kept counter, saturating at its top value.
  assign cnt_d = (kept && (cnt_q != {CNT_W{1'b1}})) ? CNT_W'(cnt_q + 1'b1) : cnt_q;

  always_comb begin
    res.kept        = kept;
    res.voxel_index = kept ? b_task_q.vidx : '0;
    res.point_id    = kept ? VIDX_W'(cnt_q) : '0;
    res.rel_x       = kept ? b_task_q.rel_x : '0;
    res.rel_y       = kept ? b_task_q.rel_y : '0;
    res.rel_z       = kept ? b_task_q.rel_z : '0;
    res.kept_count  = cnt_d;
  end

  assign res_pop = pop && !empty;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
      b_v_q     <= 1'b0;
      fwd_v_q   <= 1'b0;
      cnt_q     <= '0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
      b_v_q     <= take;
      cnt_q     <= cnt_d;
      if (kept) begin
        fwd_v_q <= 1'b1;
      end
      if (b_v_q) begin
        res_wr_q <= (res_wr_q == RPTR_W'(RDEPTH - 1)) ? '0 : RPTR_W'(res_wr_q + 1'b1);
      end
      if (res_pop) begin
        res_rd_q <= (res_rd_q == RPTR_W'(RDEPTH - 1)) ? '0 : RPTR_W'(res_rd_q + 1'b1);
      end
      if (b_v_q && !res_pop) begin
        res_cnt_q <= RCNT_W'(res_cnt_q + 1'b1);
      end else if (res_pop && !b_v_q) begin
        res_cnt_q <= RCNT_W'(res_cnt_q - 1'b1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take) begin
      b_task_q <= task_i;
    end
    if (kept) begin
      fwd_row_q  <= b_task_q.row;
      fwd_data_q <= new_row;
    end
    if (b_v_q) begin
      res_mem[res_wr_q] <= res;
    end
  end

  assign result_o = res_mem[res_rd_q];
  assign empty    = (res_cnt_q == '0);

  `ASSERT_IMPLIES(a_res_no_overflow, b_v_q && !res_pop, res_cnt_q != RCNT_W'(RDEPTH), "result queue overflow")
  `ASSERT_NEXT(a_cnt_monotonic, 1'b1, cnt_q >= $past(cnt_q), "kept counter went down")
  `ASSERT_IMPLIES(a_clear_quiet, clearing, !b_v_q && !fwd_v_q, "bitmap used during clearing pass")

endmodule

@@ sv/voxel_first_point_filter_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_first_point_filter_unit
// Keeps the first point that falls into each voxel of a cubic region and
// reports it relative to the centroid with a sequential id.
//
//   Channel   Direction  Handshake               Payload
//   points    in         push / full             point_i  (vfpf_pkg::point_t)
//   results   out        empty / pop             result_o (vfpf_pkg::result_t)
//   config    in         cfg_we_i, cfg_idx_i     cfg_wdata_i
//
// One transaction is accepted per cycle while full is low; each point gives
// one result after the two index stages, task queue, bitmap read and result
// queue. The bitmap row read-modify-write in the back sets the sustained
// rate of one point per cycle while the result queue has room; a same-row
// write is forwarded to the next point. After reset the back clears all
// SIDE*SIDE bitmap rows (1024 at SIDE = 32), one row per cycle, with full
// held high; config writes are taken. When pop stalls, the result queue
// fills and the task queue then holds full high until space frees up.
// ----------------------------------------------------------------------------
module voxel_first_point_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  vfpf_pkg::point_t                    point_i,
  output logic                                full,
  input  logic                                pop,
  output vfpf_pkg::result_t                   result_o,
  output logic                                empty,
  input  logic                                cfg_we_i,
  input  logic [vfpf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vfpf_pkg::COORD_W-1:0]        cfg_wdata_i
);
  import vfpf_pkg::*;

  cfg_t      cfg_q;
  logic      clr_busy;
  logic      task_push, task_pop;
  task_t     task_in, task_out;
  q_status_t q_status;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x         <= '0;
      cfg_q.origin_y         <= '0;
      cfg_q.origin_z         <= '0;
      cfg_q.centre_x         <= '0;
      cfg_q.centre_y         <= '0;
      cfg_q.centre_z         <= '0;
      cfg_q.voxel_reciprocal <= RECIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: cfg_q.origin_x         <= cfg_wdata_i;
        REG_ORIGIN_Y: cfg_q.origin_y         <= cfg_wdata_i;
        REG_ORIGIN_Z: cfg_q.origin_z         <= cfg_wdata_i;
        REG_CENTRE_X: cfg_q.centre_x         <= cfg_wdata_i;
        REG_CENTRE_Y: cfg_q.centre_y         <= cfg_wdata_i;
        REG_CENTRE_Z: cfg_q.centre_z         <= cfg_wdata_i;
        REG_RECIP:    cfg_q.voxel_reciprocal <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify.
  vfpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clr_busy_i  (clr_busy),
    .push        (push),
    .point_i     (point_i),
    .full        (full),
    .q_status_i  (q_status),
    .task_push_o (task_push),
    .task_o      (task_in)
  );

  // Decoupling queue.
  vfpf_task_queue u_task_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (task_push),
    .task_i   (task_in),
    .pop_i    (task_pop),
    .task_o   (task_out),
    .status_o (q_status)
  );

  // Back: bitmap update and result queue.
  vfpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .task_i     (task_out),
    .task_pop_o (task_pop),
    .clr_busy_o (clr_busy),
    .pop        (pop),
    .result_o   (result_o),
    .empty      (empty)
  );

endmodule
